@@ hdl/utf8_to_utf16le_transcoder_macros.svh @@
// assertion macros for the utf-8 to utf-16le transcoder checker
// expects clk_i, rst_ni and out_valid_o to be visible where used
`ifndef UTF8_TO_UTF16LE_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16LE_TRANSCODER_MACROS_SVH

// clocked property, masked while in reset
`define U8U16_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that must hold on every presented output beat
`define U8U16_ASSERT_BEAT(label, cond, msg) \
  `U8U16_ASSERT(label, out_valid_o |-> (cond), msg)

`endif

@@ hdl/u8u16_pkg.sv @@
// shared types and constants of the utf-8 to utf-16le transcoder
// no dependencies
package u8u16_pkg;

  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned TOTAL_W    = 20;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00dfff;
  localparam logic [20:0] CP_MAX       = 21'h10ffff;
  localparam logic [20:0] CP_MIN_2     = 21'h000080;
  localparam logic [20:0] CP_MIN_3     = 21'h000800;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

  localparam logic [2:0] SEQ_LEN_1 = 3'd1;
  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  typedef enum logic [1:0] {
    KIND_DATA2,
    KIND_DATA4,
    KIND_ERR,
    KIND_CLOSE_ERR
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        done;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } entry_t;

endpackage

@@ hdl/u8u16_front.sv @@
// front end: utf-8 decode, validity checks and sticky error state
// depends on u8u16_pkg; pushes one entry per byte that causes results
module u8u16_front import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  input  logic        final_byte_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [20:0] accum_q, accum_d;
  logic [1:0]  pending_q, pending_d;
  logic [2:0]  seq_q, seq_d;
  logic        err_q, err_d;

  logic [20:0] accum_ext;
  logic [20:0] cp;
  logic [20:0] v;
  logic [2:0]  cp_seq;
  logic        have;
  logic        bad_dec;
  logic        bad;

  assign accum_ext = {accum_q[14:0], in_byte_i[5:0]};
  assign v         = cp - CP_SUPP_BASE;

  always_comb begin
    accum_d = accum_q;
    pending_d = pending_q;
    seq_d = seq_q;
    err_d = err_q;
    have = 1'b0;
    bad_dec = 1'b0;
    cp = accum_ext;
    cp_seq = seq_q;
    if (pending_q == 2'd0) begin
      if (in_byte_i[7] == 1'b0) begin
        cp = {13'd0, in_byte_i};
        cp_seq = SEQ_LEN_1;
        seq_d = SEQ_LEN_1;
        have = 1'b1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        accum_d = {16'd0, in_byte_i[4:0]};
        seq_d = SEQ_LEN_2;
        pending_d = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        accum_d = {17'd0, in_byte_i[3:0]};
        seq_d = SEQ_LEN_3;
        pending_d = 2'd2;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        accum_d = {18'd0, in_byte_i[2:0]};
        seq_d = SEQ_LEN_4;
        pending_d = 2'd3;
      end else begin
        bad_dec = 1'b1;
      end
    end else if (in_byte_i[7:6] != 2'b10) begin
      bad_dec = 1'b1;
    end else begin
      accum_d = accum_ext;
      pending_d = pending_q - 2'd1;
      if (pending_q == 2'd1) begin
        have = 1'b1;
        accum_d = '0;
      end
    end

    bad = bad_dec;
    if (have) begin
      if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) bad = 1'b1;
      if (cp_seq == SEQ_LEN_2 && cp < CP_MIN_2) bad = 1'b1;
      if (cp_seq == SEQ_LEN_3 && cp < CP_MIN_3) bad = 1'b1;
      if (cp_seq == SEQ_LEN_4 && cp < CP_SUPP_BASE) bad = 1'b1;
      if (cp > CP_MAX) bad = 1'b1;
    end
    if (final_byte_i && !have) bad = 1'b1;

    if (err_q) begin
      accum_d = accum_q;
      pending_d = pending_q;
      seq_d = seq_q;
    end else if (bad) begin
      err_d = 1'b1;
      pending_d = 2'd0;
      accum_d = '0;
    end

    if (final_byte_i) begin
      accum_d = '0;
      pending_d = 2'd0;
      seq_d = '0;
      err_d = 1'b0;
    end
  end

  always_comb begin
    entry_o.done = final_byte_i;
    entry_o.unit0 = cp[15:0];
    entry_o.unit1 = '0;
    entry_o.kind = KIND_DATA2;
    push_o = 1'b0;
    if (final_byte_i && (err_q || bad)) begin
      entry_o.kind = KIND_CLOSE_ERR;
      push_o = accept_i;
    end else if (!err_q && bad) begin
      entry_o.kind = KIND_ERR;
      push_o = accept_i;
    end else if (!err_q && have) begin
      push_o = accept_i;
      if (cp > 21'h00ffff) begin
        entry_o.kind = KIND_DATA4;
        entry_o.unit0 = {HI_SURR_TAG, v[19:10]};
        entry_o.unit1 = {LO_SURR_TAG, v[9:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      pending_q <= '0;
      seq_q <= '0;
      err_q <= 1'b0;
    end else if (accept_i) begin
      accum_q <= accum_d;
      pending_q <= pending_d;
      seq_q <= seq_d;
      err_q <= err_d;
    end
  end

endmodule

@@ hdl/u8u16_fifo.sv @@
// small entry queue between the decode front end and the byte emitter
// depends on u8u16_pkg
module u8u16_fifo import u8u16_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= PTR_W'((32'(wr_q) + 1) % FIFO_DEPTH);
      if (do_pop) rd_q <= PTR_W'((32'(rd_q) + 1) % FIFO_DEPTH);
      if (push_i && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (!push_i && do_pop) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

@@ hdl/u8u16_back.sv @@
// back end: emits utf-16le bytes, error beats and the byte count
// depends on u8u16_pkg; takes entries from the queue
module u8u16_back import u8u16_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  entry_t             entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               string_done_o,
  output logic               malformed_o,
  output logic [TOTAL_W-1:0] total_bytes_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  entry_t                ent_q;
  logic                  vld_q;
  logic [1:0]            idx_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  is_data;
  logic                  last_beat;
  logic                  fire;
  logic                  load;

  assign is_data = (ent_q.kind == KIND_DATA2) || (ent_q.kind == KIND_DATA4);
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign fire    = vld_q && out_ready_i;
  assign load    = !vld_q || (fire && last_beat);
  assign pop_o   = load && !empty_i;

  always_comb begin
    case (ent_q.kind)
      KIND_DATA2: last_beat = (idx_q == 2'd1);
      KIND_DATA4: last_beat = (idx_q == 2'd3);
      default:    last_beat = 1'b1;
    endcase
  end

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = ent_q.unit0[7:0];
      2'd1:    out_byte_o = ent_q.unit0[15:8];
      2'd2:    out_byte_o = ent_q.unit1[7:0];
      default: out_byte_o = ent_q.unit1[15:8];
    endcase
    if (!is_data) out_byte_o = '0;
  end

  assign out_valid_o   = vld_q;
  assign run_last_o    = last_beat;
  assign string_done_o = last_beat && ent_q.done && (ent_q.kind != KIND_ERR);
  assign malformed_o   = !is_data;
  assign total_bytes_o = is_data ? TOTAL_W'(cnt_inc) : TOTAL_W'(cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (string_done_o) cnt_d = '0;
      else if (is_data) cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (load) begin
        vld_q <= !empty_i;
        idx_q <= '0;
      end else if (fire) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

@@ hdl/utf8_to_utf16le_transcoder.sv @@
// top level of the utf-8 to utf-16le transcoder
// depends on u8u16_pkg, u8u16_front, u8u16_fifo, u8u16_back
//
//  channel | signals                                   | dir | beat
//  --------+-------------------------------------------+-----+---------------------
//  in      | in_valid_i in_ready_o in_byte_i           | in  | one utf-8 byte
//          | final_byte_i                              |     |
//  out     | out_valid_o out_ready_i out_byte_o        | out | one utf-16le byte or
//          | run_last_o string_done_o malformed_o      |     | error/close report
//          | total_bytes_o                             |     |
//
//  one input byte per cycle if not full; a byte is decoded in the cycle it is taken
//  results leave the emitter one beat per cycle while out_ready_i is high
//  a four-entry queue decouples decode from emission; input stalls only when full
//  a code point of four output bytes holds the emitter until all four are taken
//  reset clears decode state, queue and byte count
module utf8_to_utf16le_transcoder import u8u16_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               final_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               string_done_o,
  output logic               malformed_o,
  output logic [TOTAL_W-1:0] total_bytes_o
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  entry_t wentry;
  entry_t rentry;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push),
    .entry_o      (wentry)
  );

  u8u16_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .empty_o (empty),
    .full_o  (full)
  );

  u8u16_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (rentry),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o),
    .malformed_o   (malformed_o),
    .total_bytes_o (total_bytes_o)
  );

endmodule

@@ hdl/u8u16_checker.sv @@
// port-level checks for the utf-8 to utf-16le transcoder
// depends on u8u16_pkg and utf8_to_utf16le_transcoder_macros.svh; bound to the top level
`include "utf8_to_utf16le_transcoder_macros.svh"

module u8u16_checker import u8u16_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         out_byte_o,
  input logic               run_last_o,
  input logic               string_done_o,
  input logic               malformed_o,
  input logic [TOTAL_W-1:0] total_bytes_o
);

  `U8U16_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o),
                "stalled output beat changed")
  `U8U16_ASSERT_BEAT(a_done_last, !string_done_o || run_last_o, "string close not on last beat")
  `U8U16_ASSERT_BEAT(a_err_zero, !malformed_o || out_byte_o == 8'd0, "error beat with data byte")
  `U8U16_ASSERT_BEAT(a_data_count, malformed_o || total_bytes_o != '0, "data beat with zero count")

endmodule

bind utf8_to_utf16le_transcoder u8u16_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .run_last_o    (run_last_o),
  .string_done_o (string_done_o),
  .malformed_o   (malformed_o),
  .total_bytes_o (total_bytes_o)
);
